// ===== rtl/depth_cued_phong_shader_assert.svh =====
// assertion macros for the depth-cued phong shader
`ifndef DEPTH_CUED_PHONG_SHADER_ASSERT_SVH
`define DEPTH_CUED_PHONG_SHADER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcps assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define DCPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcps assertion failed");

`endif

// ===== rtl/dcps_pkg.sv =====
// shared constants and types of the depth-cued phong shader
`timescale 1ns / 1ps
package dcps_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int MAX_EXPONENT   = 16;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [15:0] COS_ONE = 16'd32768;

  localparam logic [15:0] AMBIENT_RST  = 16'd3277;
  localparam logic [15:0] DIFFUSE_RST  = 16'd9830;
  localparam logic [15:0] SPECULAR_RST = 16'd6554;
  localparam logic [4:0]  EXPONENT_RST = 5'd10;
  localparam logic [15:0] OFFSET_RST   = 16'd4096;
  localparam logic [15:0] STRETCH_RST  = 16'd20480;
  localparam logic [14:0] DIAG_RST     = 15'd3547;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AMBIENT  = 3'd0,
    REG_DIFFUSE  = 3'd1,
    REG_SPECULAR = 3'd2,
    REG_EXPONENT = 3'd3,
    REG_OFFSET   = 3'd4,
    REG_STRETCH  = 3'd5,
    REG_DIAG     = 3'd6
  } cfg_reg_t;

endpackage

// ===== rtl/dcps_if.sv =====
// pixel stream interfaces with valid/ready handshake
`timescale 1ns / 1ps
interface dcps_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] depth;
  logic        [15:0] normal_cos;
  logic        [7:0]  luma_in;
  logic        [7:0]  cb_in;
  logic        [7:0]  cr_in;

  modport source (output valid, depth, normal_cos, luma_in, cb_in, cr_in, input ready);
  modport sink   (input valid, depth, normal_cos, luma_in, cb_in, cr_in, output ready);
endinterface

interface dcps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;
  logic [7:0] cb_out;
  logic [7:0] cr_out;

  modport source (output valid, luma_out, cb_out, cr_out, input ready);
  modport sink   (input valid, luma_out, cb_out, cr_out, output ready);
endinterface

// ===== rtl/depth_cued_phong_shader.sv =====
// top level of the depth-cued phong shader
//
//  channel    | dir | handshake     | payload
//  -----------+-----+---------------+----------------------------------------
//  pixel_in   | in  | valid/ready   | depth, normal_cos, luma_in, cb_in, cr_in
//  pixel_out  | out | valid/ready   | luma_out, cb_out, cr_out
//  cfg        | in  | cfg_we        | cfg_index, cfg_data
//
// one pixel per cycle while the output takes its transactions; the whole pipe
// advances together; when the output holds an untaken transaction, every stage
// holds and pixel_in.ready drops
// synchronous active-high reset clears the valid bits and loads the
// configuration registers with their reset values
`timescale 1ns / 1ps
`include "depth_cued_phong_shader_assert.svh"
module depth_cued_phong_shader
  import dcps_pkg::*;
#(
  parameter int COEF_FRAC = COEF_FRAC_BITS,
  parameter int MAX_EXP   = MAX_EXPONENT
) (
  input  logic                   clk,
  input  logic                   rst,
  dcps_in_if.sink                pixel_in,
  dcps_out_if.source             pixel_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int N_W    = $clog2(MAX_EXP + 1);
  localparam int NUM_W  = 32 + COEF_FRAC;
  localparam int HALF   = (NUM_W + 1) / 2;
  localparam int SP_W   = NUM_W + 16;
  localparam int SPX_W  = (SP_W > 64) ? SP_W : 65;
  localparam int A_IDX  = NUM_W + 4;
  localparam int B_IDX  = MAX_EXP + 2;
  localparam int ALIGN  = (A_IDX > B_IDX) ? A_IDX : B_IDX;
  localparam int TOTAL  = ALIGN + 5;

  // configuration registers
  logic [15:0] ambient_gain, diffuse_gain, specular_gain, depth_offset, depth_stretch;
  logic [4:0]  specular_exponent;
  logic [14:0] half_diagonal;

  always_ff @(posedge clk) begin
    if (rst) begin
      ambient_gain      <= AMBIENT_RST;
      diffuse_gain      <= DIFFUSE_RST;
      specular_gain     <= SPECULAR_RST;
      specular_exponent <= EXPONENT_RST;
      depth_offset      <= OFFSET_RST;
      depth_stretch     <= STRETCH_RST;
      half_diagonal     <= DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_AMBIENT:  ambient_gain      <= cfg_data;
        REG_DIFFUSE:  diffuse_gain      <= cfg_data;
        REG_SPECULAR: specular_gain     <= cfg_data;
        REG_EXPONENT: specular_exponent <= cfg_data[4:0];
        REG_OFFSET:   depth_offset      <= cfg_data;
        REG_STRETCH:  depth_stretch     <= cfg_data;
        REG_DIAG:     half_diagonal     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [TOTAL-1:0] vld;
  logic             adv;

  assign adv            = !vld[TOTAL-1] || pixel_out.ready;
  assign pixel_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[TOTAL-2:0], pixel_in.valid && pixel_in.ready};
  end

  // stage 0: cosine clamp, specular base, depth distance, divisor
  logic [14:0] diag_eff;
  logic [15:0] c_sat;
  logic [31:0] csq;
  logic [31:0] csq_off;
  logic [16:0] dd;
  logic [16:0] dd_neg;
  logic [29:0] diag_sq;
  logic [N_W-1:0] n_eff;

  assign diag_eff = (half_diagonal == '0) ? 15'd1 : half_diagonal;
  assign c_sat    = (pixel_in.normal_cos > COS_ONE) ? COS_ONE : pixel_in.normal_cos;
  assign csq      = c_sat * c_sat;
  assign csq_off  = csq - 32'h2000_0000;
  assign dd       = {2'b00, diag_eff} - {pixel_in.depth[15], pixel_in.depth};
  assign dd_neg   = -dd;
  assign diag_sq  = diag_eff * diag_eff;

  always_comb begin
    if (specular_exponent == '0) n_eff = N_W'(1);
    else if (32'(specular_exponent) > MAX_EXP) n_eff = N_W'(MAX_EXP);
    else n_eff = N_W'(specular_exponent);
  end

  logic [15:0] s0_c, s0_a, s0_ad;
  logic [31:0] s0_den;
  logic [7:0]  s0_y, s0_cb, s0_cr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_c   <= c_sat;
      // below cos 45 the specular base is zero, so every power is zero
      s0_a   <= (csq >= 32'h2000_0000) ? csq_off[29:14] : 16'd0;
      s0_ad  <= dd[16] ? dd_neg[15:0] : dd[15:0];
      s0_den <= {diag_sq, 2'b00};
      s0_y   <= pixel_in.luma_in;
      s0_cb  <= pixel_in.cb_in;
      s0_cr  <= pixel_in.cr_in;
    end
  end

  // depth cue path
  logic [31:0]      ad_sq;
  logic [NUM_W-1:0] s1_num;
  logic [31:0]      s1_den;
  logic [NUM_W-1:0] ratio;

  assign ad_sq = s0_ad * s0_ad;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num <= NUM_W'(ad_sq) << COEF_FRAC;
      s1_den <= s0_den;
    end
  end

  dcps_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
    .clk (clk),
    .en  (adv),
    .num (s1_num),
    .den (s1_den),
    .quo (ratio)
  );

  logic [HALF+15:0]       sp_lo;
  logic [NUM_W-HALF+15:0] sp_hi;
  logic [SPX_W-1:0]       spx;
  logic [63:0]            sp;
  logic                   sp_sat;
  logic [63:0]            kz;
  logic [63:0]            kz_al;

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_lo <= depth_stretch * ratio[HALF-1:0];
      sp_hi <= depth_stretch * ratio[NUM_W-1:HALF];
    end
  end

  assign spx = SPX_W'(sp_lo) + (SPX_W'(sp_hi) << HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      sp     <= spx[63:0];
      sp_sat <= spx >= SPX_W'(64'hFFFF_FFFF_FFFF_FFFF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) kz <= sp_sat ? '1 : 64'(depth_offset) + (sp >> COEF_FRAC);
  end

  dcps_delay #(.W(64), .N(ALIGN - A_IDX)) u_kz_dly (
    .clk (clk), .en (adv), .d (kz), .q (kz_al)
  );

  // lighting path
  logic [15:0] fb;
  logic [15:0] c_al;
  logic [7:0]  y_al;

  dcps_spec #(.MAX_EXP(MAX_EXP)) u_spec (
    .clk (clk),
    .en  (adv),
    .a   (s0_a),
    .n   (n_eff),
    .fb  (fb)
  );

  dcps_delay #(.W(24), .N(MAX_EXP - 1)) u_cy_dly (
    .clk (clk), .en (adv), .d ({s0_c, s0_y}), .q ({c_al, y_al})
  );

  logic [31:0] md, ms;
  logic [7:0]  y1;
  logic [39:0] td, ts;
  logic [40:0] lit_sum;
  logic [25:0] inner;
  logic [25:0] inner_al;

  always_ff @(posedge clk) begin
    if (adv) begin
      md <= diffuse_gain * c_al;
      ms <= specular_gain * fb;
      y1 <= y_al;
      td <= md * y1;
      ts <= ms * y1;
    end
  end

  assign lit_sum = {1'b0, td} + {1'b0, ts};

  always_ff @(posedge clk) begin
    if (adv) inner <= lit_sum[40:15];
  end

  dcps_delay #(.W(26), .N(ALIGN - B_IDX)) u_inner_dly (
    .clk (clk), .en (adv), .d (inner), .q (inner_al)
  );

  // final mix: kz * inner in 16-bit slices, then ambient and clamp
  logic [41:0] pk [4];
  logic [57:0] s01, s23;
  logic [89:0] prod;
  logic [63:0] p_lo;
  logic        psat;
  logic [64:0] total;
  logic [7:0]  luma;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) pk[k] <= kz_al[16*k +: 16] * inner_al;
      s01 <= 58'(pk[0]) + (58'(pk[1]) << 16);
      s23 <= 58'(pk[2]) + (58'(pk[3]) << 16);
    end
  end

  assign prod = 90'(s01) + (90'(s23) << 32);

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo <= prod[63:0];
      psat <= prod >= 90'(64'hFFFF_FFFF_FFFF_FFFF);
    end
  end

  assign total = 65'(ambient_gain) * 65'd255 + 65'(p_lo >> COEF_FRAC);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (psat || (total >> COEF_FRAC) > 65'd255) luma <= 8'd255;
      else luma <= total[COEF_FRAC +: 8];
    end
  end

  logic [15:0] chroma_al;

  dcps_delay #(.W(16), .N(ALIGN + 4)) u_chroma_dly (
    .clk (clk), .en (adv), .d ({s0_cb, s0_cr}), .q (chroma_al)
  );

  assign pixel_out.valid    = vld[TOTAL-1];
  assign pixel_out.luma_out = luma;
  assign pixel_out.cb_out   = chroma_al[15:8];
  assign pixel_out.cr_out   = chroma_al[7:0];

  `DCPS_ASSERT_NEXT(a_accept_enters, pixel_in.valid && pixel_in.ready, vld[0])
  `DCPS_ASSERT_NOW(a_stall_blocks_input, pixel_out.valid && !pixel_out.ready,
                   !pixel_in.ready)
  `DCPS_ASSERT_NEXT(a_overflow_saturates, adv && vld[TOTAL-2] && psat,
                    pixel_out.luma_out == 8'd255)

endmodule

// ===== rtl/dcps_delay.sv =====
// enabled shift line that delays a word by a fixed number of stages
`timescale 1ns / 1ps
module dcps_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (N == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] line [N];
      always_ff @(posedge clk) begin
        if (en) begin
          line[0] <= d;
          for (int i = 1; i < N; i++) line[i] <= line[i-1];
        end
      end
      assign q = line[N-1];
    end
  endgenerate

endmodule

// ===== rtl/dcps_spec.sv =====
// specular power chain, one multiply per stage
`timescale 1ns / 1ps
module dcps_spec #(
  parameter int MAX_EXP = 16,
  localparam int N_W    = $clog2(MAX_EXP + 1)
) (
  input  logic           clk,
  input  logic           en,
  input  logic [15:0]    a,
  input  logic [N_W-1:0] n,
  output logic [15:0]    fb
);

  localparam int ST = MAX_EXP - 1;

  generate
    if (ST == 0) begin : g_none
      assign fb = a;
    end else begin : g_chain
      logic [15:0] r  [ST];
      logic [15:0] av [ST];
      for (genvar k = 0; k < ST; k++) begin : g_st
        logic [15:0] r_prev;
        logic [15:0] a_prev;
        logic [31:0] prod;
        localparam logic [N_W-1:0] ITER = N_W'(k + 1);
        if (k == 0) begin : g_first
          assign r_prev = a;
          assign a_prev = a;
        end else begin : g_rest
          assign r_prev = r[k-1];
          assign a_prev = av[k-1];
        end
        assign prod = r_prev * a_prev;
        always_ff @(posedge clk) begin
          if (en) begin
            av[k] <= a_prev;
            // product never exceeds 2^30, so bits 30:15 hold the scaled product without overflow
            r[k]  <= (ITER < n) ? prod[30:15] : r_prev;
          end
        end
      end
      assign fb = r[ST-1];
    end
  endgenerate

endmodule

// ===== rtl/dcps_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module dcps_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem  [NUM_W];
  logic [NUM_W-1:0] qv   [NUM_W];
  logic [NUM_W-1:0] nv   [NUM_W];
  logic [DEN_W-1:0] dv   [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_st
    logic [DEN_W-1:0] rem_prev;
    logic [NUM_W-1:0] q_prev;
    logic [NUM_W-1:0] n_prev;
    logic [DEN_W-1:0] d_prev;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;
    if (i == 0) begin : g_first
      assign rem_prev = '0;
      assign q_prev   = '0;
      assign n_prev   = num;
      assign d_prev   = den;
    end else begin : g_rest
      assign rem_prev = rem[i-1];
      assign q_prev   = qv[i-1];
      assign n_prev   = nv[i-1];
      assign d_prev   = dv[i-1];
    end
    assign trial = {rem_prev, n_prev[NUM_W-1]};
    assign ge    = trial >= {1'b0, d_prev};
    assign diff  = trial - {1'b0, d_prev};
    always_ff @(posedge clk) begin
      if (en) begin
        // remainder stays below the divisor
        rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qv[i]  <= {q_prev[NUM_W-2:0], ge};
        nv[i]  <= {n_prev[NUM_W-2:0], 1'b0};
        dv[i]  <= d_prev;
      end
    end
  end

  assign quo = qv[NUM_W-1];

endmodule

// ===== test/depth_cued_phong_shader_tb.sv =====
// self-checking testbench for the depth-cued phong shader: random stalls, config sweeps
`timescale 1ns / 1ps
module depth_cued_phong_shader_tb
  import dcps_pkg::*;
();

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 5000;

  typedef struct packed {
    logic signed [15:0] depth;
    logic        [15:0] normal_cos;
    logic        [7:0]  luma_in;
    logic        [7:0]  cb_in;
    logic        [7:0]  cr_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } shaded_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dcps_in_if  pin ();
  dcps_out_if pout ();

  depth_cued_phong_shader dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pin),
    .pixel_out (pout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the shading registers
  logic [15:0] ka_r, kd_r, ks_r, off_r, str_r;
  logic [4:0]  exp_r;
  logic [14:0] diag_r;

  pixel_t  pixel_q[$];
  shaded_t shaded_q[$];

  int  errors;
  int  pixels_sent;
  int  pixels_shaded;
  int  saturated_seen;
  int  idle_cycles;
  bit  src_idle_on;
  bit  sink_idle_on;
  int  long_hold_req;
  int  src_gap;
  int  sink_hold;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] shade_luma(logic signed [15:0] depth, logic [15:0] cos_in,
                                             logic [7:0] y);
    logic [63:0] c, y64, n, dg, ad, ratio, kz, fb, a, r, sq2, inner, total, lum;
    logic [127:0] sp, prod;
    longint dd;
    c   = (cos_in > COS_ONE) ? 64'(COS_ONE) : 64'(cos_in);
    y64 = 64'(y);
    n   = (exp_r == 0) ? 64'd1 : ((exp_r > MAX_EXPONENT) ? 64'(MAX_EXPONENT) : 64'(exp_r));
    dg  = (diag_r == 0) ? 64'd1 : 64'(diag_r);
    dd  = longint'(dg) - longint'(depth);
    ad  = (dd < 0) ? 64'(-dd) : 64'(dd);
    ratio = ((ad * ad) << COEF_FRAC_BITS) / (64'd4 * dg * dg);
    sp  = 128'(str_r) * 128'(ratio);
    if (sp >= 128'(64'hFFFF_FFFF_FFFF_FFFF)) begin
      kz = 64'hFFFF_FFFF_FFFF_FFFF;
    end else begin
      kz = 64'(off_r) + (sp[63:0] >> COEF_FRAC_BITS);
    end
    // specular term only above 45 degrees
    sq2 = 64'd2 * c * c;
    if (sq2 < (64'd1 << 30)) begin
      fb = 0;
    end else begin
      a = (sq2 - (64'd1 << 30)) >> 15;
      r = a;
      for (int k = 1; k < n; k++) r = (r * a) >> 15;
      fb = r;
    end
    inner = (64'(kd_r) * c * y64 + 64'(ks_r) * fb * y64) >> 15;
    prod  = 128'(kz) * 128'(inner);
    if (prod >= 128'(64'hFFFF_FFFF_FFFF_FFFF)) begin
      lum = 255;
    end else begin
      total = 64'd255 * 64'(ka_r) + (prod[63:0] >> COEF_FRAC_BITS);
      lum   = total >> COEF_FRAC_BITS;
      if (lum > 255) lum = 255;
    end
    return lum[7:0];
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             pixels_shaded);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_AMBIENT:  ka_r   = val;
      REG_DIFFUSE:  kd_r   = val;
      REG_SPECULAR: ks_r   = val;
      REG_EXPONENT: exp_r  = val[4:0];
      REG_OFFSET:   off_r  = val;
      REG_STRETCH:  str_r  = val;
      REG_DIAG:     diag_r = val[14:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] ka, logic [15:0] kd, logic [15:0] ks, logic [15:0] ex,
                         logic [15:0] off, logic [15:0] str, logic [15:0] dg);
    write_reg(REG_AMBIENT, ka);
    write_reg(REG_DIFFUSE, kd);
    write_reg(REG_SPECULAR, ks);
    write_reg(REG_EXPONENT, ex);
    write_reg(REG_OFFSET, off);
    write_reg(REG_STRETCH, str);
    write_reg(REG_DIAG, dg);
    end_writes();
  endtask

  // look after the edge so that the driver and monitor updates are visible
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || pin.valid || shaded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(logic [15:0] z, logic [15:0] c, logic [7:0] y, logic [7:0] cb,
                            logic [7:0] cr);
    pixel_t p;
    p.depth = z;
    p.normal_cos = c;
    p.luma_in = y;
    p.cb_in = cb;
    p.cr_in = cr;
    pixel_q.push_back(p);
  endtask

  task automatic push_random(int count);
    logic [15:0] z, c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: z = 16'($urandom);
        1: z = 16'($urandom_range(8000)) - 16'd4000;
        2: z = 16'(diag_r) + 16'($urandom_range(64)) - 16'd32;
        default: z = $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3))
                                       : 16'h8000 + 16'($urandom_range(3));
      endcase
      case ($urandom_range(3))
        0: c = 16'($urandom);
        1: c = 16'($urandom_range(32768, 23100));
        2: c = 16'($urandom_range(32768));
        default: c = $urandom_range(1) ? COS_ONE : 16'hFFFF - 16'($urandom_range(8));
      endcase
      push_pixel(z, c, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    end
  endtask

  // driver
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      pin.valid <= 1'b0;
      src_gap <= 0;
    end else if (!pin.valid || pin.ready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        pin.valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        p = pixel_q.pop_front();
        pin.valid      <= 1'b1;
        pin.depth      <= p.depth;
        pin.normal_cos <= p.normal_cos;
        pin.luma_in    <= p.luma_in;
        pin.cb_in      <= p.cb_in;
        pin.cr_in      <= p.cr_in;
        src_gap <= src_idle_on ? pick_gap() : 0;
      end else begin
        pin.valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pout.ready <= 1'b0;
      sink_hold <= 0;
    end else if (long_hold_req > 0) begin
      pout.ready <= 1'b0;
      sink_hold <= long_hold_req;
      long_hold_req <= 0;
    end else if (sink_hold > 0) begin
      pout.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_idle_on && $urandom_range(99) < 25) begin
      pout.ready <= 1'b0;
      sink_hold <= pick_gap();
    end else begin
      pout.ready <= 1'b1;
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    shaded_t want;
    if (!rst) begin
      if (pin.valid && pin.ready) begin
        want.luma = shade_luma(pin.depth, pin.normal_cos, pin.luma_in);
        want.cb   = pin.cb_in;
        want.cr   = pin.cr_in;
        if (want.luma == 8'd255) saturated_seen++;
        shaded_q.push_back(want);
        pixels_sent++;
      end
      if (pout.valid && pout.ready) begin
        if (shaded_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = shaded_q.pop_front();
          if (pout.luma_out !== want.luma)
            report_mismatch("luma_out", int'(pout.luma_out), int'(want.luma));
          if (pout.cb_out !== want.cb)
            report_mismatch("cb_out", int'(pout.cb_out), int'(want.cb));
          if (pout.cr_out !== want.cr)
            report_mismatch("cr_out", int'(pout.cr_out), int'(want.cr));
        end
        pixels_shaded++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (pin.valid && pin.ready) || (pout.valid && pout.ready) ||
        (pixel_q.size() == 0 && shaded_q.size() == 0 && !pin.valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin.valid = 1'b0;
    pin.depth = '0;
    pin.normal_cos = '0;
    pin.luma_in = '0;
    pin.cb_in = '0;
    pin.cr_in = '0;
    pout.ready = 1'b0;
    errors = 0;
    pixels_sent = 0;
    pixels_shaded = 0;
    saturated_seen = 0;
    idle_cycles = 0;
    long_hold_req = 0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    ka_r = AMBIENT_RST;
    kd_r = DIFFUSE_RST;
    ks_r = SPECULAR_RST;
    exp_r = EXPONENT_RST;
    off_r = OFFSET_RST;
    str_r = STRETCH_RST;
    diag_r = DIAG_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed corners at reset settings
    push_pixel(16'h0000, 16'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(16'h7FFF, COS_ONE, 8'd255, 8'd255, 8'd255);
    push_pixel(16'h8000, COS_ONE, 8'd255, 8'hAA, 8'h55);
    push_pixel(16'hFFFF, 16'hFFFF, 8'd200, 8'h55, 8'hAA);
    push_pixel(16'd3547, 16'd23170, 8'd128, 8'd1, 8'd254);
    push_pixel(16'd3547, 16'd23171, 8'd128, 8'd2, 8'd253);
    push_pixel(-16'sd3547, 16'd32767, 8'd1, 8'd3, 8'd128);
    push_pixel(16'h1234, 16'd32769, 8'd77, 8'd4, 8'd127);
    push_pixel(16'h8000, 16'd16384, 8'd255, 8'd5, 8'd0);
    push_pixel(16'h4000, 16'd30000, 8'd99, 8'd6, 8'd9);
    drain();

    // extremes: large gains, exponent at the cap, widest diagonal
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    push_pixel(16'h8000, COS_ONE, 8'd255, 8'd7, 8'd8);
    push_pixel(16'h7FFF, 16'd0, 8'd0, 8'd9, 8'd10);
    drain();
    // zero diagonal and exponent zero, huge stretch drives the product past 64 bits
    set_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    drain();
    push_pixel(16'h8000, COS_ONE, 8'd255, 8'd11, 8'd12);
    push_pixel(16'h7FFF, 16'd30000, 8'd10, 8'd13, 8'd14);
    push_pixel(16'h0001, 16'd25000, 8'd100, 8'd15, 8'd16);
    drain();
    // exponent beyond the cap, unknown register ignored
    write_reg(REG_EXPONENT, 16'd31);
    write_reg(REG_UNUSED, 16'hFFFF);
    end_writes();
    push_pixel(16'h0000, 16'd32000, 8'd255, 8'd17, 8'd18);
    push_pixel(16'h0000, COS_ONE, 8'd255, 8'd19, 8'd20);
    drain();
    // all coefficients zero, minimum diagonal
    set_all(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    push_pixel(16'h8000, COS_ONE, 8'd255, 8'd21, 8'd22);
    push_pixel(16'h0001, 16'd0, 8'd0, 8'd23, 8'd24);
    drain();

    // random phases with a fresh setting each
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_all(AMBIENT_RST, DIFFUSE_RST, SPECULAR_RST, 16'(EXPONENT_RST), OFFSET_RST,
                   STRETCH_RST, 16'(DIAG_RST));
        1: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        2: set_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1);
        3: set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: set_all(16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom_range(31)), 16'($urandom), 16'($urandom),
                         16'($urandom_range(32767)));
      endcase
      src_idle_on = (ph % 3) != 1;
      sink_idle_on = (ph % 3) != 2;
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps streaming
        src_idle_on = 1'b0;
        long_hold_req = 400;
      end
      push_random(245);
      drain();
    end

    $display("shaded %0d pixels over 12 register settings, %0d at full luma",
             pixels_shaded, saturated_seen);
    $display("covered stalls on both sides, a long output hold-off and idle reprogramming");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
